@@ rtl/vmalu_pkg.sv @@
package vmalu_pkg;

  // Data path and register file sizes.
  localparam int DATA_W    = 32;
  localparam int SHAMT_W   = $clog2(DATA_W);
  localparam int STEP_W    = $clog2(DATA_W);
  localparam int REG_COUNT = 16;
  localparam int REG_IDX_W = 4;
  localparam int REG_AW    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // Operation codes.
  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_AND = 4'd4,
    OP_OR  = 4'd5,
    OP_XOR = 4'd6,
    OP_SHL = 4'd7,
    OP_SHR = 4'd8,
    OP_INC = 4'd9,
    OP_DEC = 4'd10,
    OP_NOT = 4'd11,
    OP_CMP = 4'd12
  } op_e;

  // Operand mode codes.
  localparam logic [3:0] MODE_REG_REG      = 4'd0;
  localparam logic [3:0] MODE_MEM_DEST     = 4'd3;
  localparam logic [3:0] MODE_ADD_MEM_REG  = 4'd3;
  localparam logic [3:0] MODE_ALU_MEM_REG  = 4'd4;
  localparam logic [3:0] MODE_MAX_BIN      = 4'd5;
  localparam logic [3:0] MODE_UNARY_MEM    = 4'd1;
  localparam logic [3:0] MODE_MAX_UNARY    = 4'd1;
  localparam logic [3:0] MODE_CMP_MEM_REG  = 4'd3;
  localparam logic [3:0] MODE_CMP_IMM_REG  = 4'd6;
  localparam logic [3:0] MODE_CMP_NOT_REG  = 4'd3;
  localparam logic [3:0] MODE_MAX_CMP      = 4'd8;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_MODE = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  // One instruction request.
  typedef struct packed {
    logic [3:0]        operation;
    logic [3:0]        mode;
    logic [3:0]        dest_reg;
    logic [3:0]        src_reg;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] src_value;
  } req_t;

  // One instruction result.
  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              memory_write;
    logic              zero_flag;
    logic              carry_flag;
    logic [1:0]        status;
  } rsp_t;

  // Command to the shared arithmetic unit.
  typedef struct packed {
    op_e  op;
    logic dec_sat;
  } alu_cmd_t;

  // Completion and compare flags from the shared arithmetic unit.
  typedef struct packed {
    logic done;
    logic zero;
    logic carry;
  } alu_flags_t;

endpackage

@@ rtl/vm_alu_execute_unit.sv @@
// Channel   Direction  Payload           Handshake
// request   in         vmalu_pkg::req_t  in_valid_i / in_ready_o
// result    out        vmalu_pkg::rsp_t  out_valid_o / out_ready_i
//
// Multiply and divide run as 32 radix-2 steps of the shared adder; a request with
// a bad mode or a zero divisor bypasses the shared unit. A new request is taken
// only once the previous one has left the sequencer.
// Registers read as zero after reset through per-register valid bits.
// A result waits in the output register while the next request is worked on;
// a request finishes only once that register is free.
module vm_alu_execute_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vmalu_pkg::req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vmalu_pkg::rsp_t  out_rsp_o
);

  localparam int W = vmalu_pkg::DATA_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state_q;
  logic [1:0]             state_d;
  vmalu_pkg::req_t        req_q;
  logic [1:0]             status_q;
  logic [1:0]             status_d;
  logic                   to_mem_q;
  logic                   is_cmp_q;
  logic                   zf_q;
  logic                   cf_q;
  logic                   out_valid_q;
  vmalu_pkg::rsp_t        out_q;
  logic                   accept;
  logic                   load_out;
  logic                   ok;
  logic                   rf_we;
  logic [W-1:0]           rf_a;
  logic [W-1:0]           rf_b;
  logic                   bad_mode;
  logic                   first_mem;
  logic                   second_reg;
  logic [W-1:0]           opnd_a;
  logic [W-1:0]           opnd_b;
  logic                   div_zero;
  logic                   unit_start;
  vmalu_pkg::alu_cmd_t    unit_cmd;
  logic [W-1:0]           unit_res;
  vmalu_pkg::alu_flags_t  unit_flags;
  logic                   new_zf;
  logic                   new_cf;

  assign accept   = in_valid_i && in_ready_o;
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign ok       = (status_q == vmalu_pkg::ST_OK);
  assign rf_we    = load_out && ok && !is_cmp_q && !to_mem_q;

  vmalu_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_idx_a_i  (in_req_i.dest_reg),
    .rd_idx_b_i  (in_req_i.src_reg),
    .rd_data_a_o (rf_a),
    .rd_data_b_o (rf_b),
    .we_i        (rf_we),
    .wr_idx_i    (req_q.dest_reg),
    .wr_data_i   (unit_res)
  );

  // Mode decode and operand selection for the request held in req_q.
  always_comb begin
    bad_mode   = 1'b0;
    first_mem  = 1'b0;
    second_reg = 1'b0;
    if (req_q.operation <= vmalu_pkg::OP_SHR) begin
      bad_mode   = req_q.mode > vmalu_pkg::MODE_MAX_BIN;
      first_mem  = req_q.mode >= vmalu_pkg::MODE_MEM_DEST;
      second_reg = (req_q.mode == vmalu_pkg::MODE_REG_REG) ||
                   ((req_q.operation == vmalu_pkg::OP_ADD) ?
                    (req_q.mode == vmalu_pkg::MODE_ADD_MEM_REG) :
                    (req_q.mode == vmalu_pkg::MODE_ALU_MEM_REG));
    end else if (req_q.operation <= vmalu_pkg::OP_NOT) begin
      bad_mode  = req_q.mode > vmalu_pkg::MODE_MAX_UNARY;
      first_mem = req_q.mode == vmalu_pkg::MODE_UNARY_MEM;
    end else if (req_q.operation == vmalu_pkg::OP_CMP) begin
      bad_mode   = req_q.mode > vmalu_pkg::MODE_MAX_CMP;
      first_mem  = req_q.mode >= vmalu_pkg::MODE_CMP_NOT_REG;
      second_reg = req_q.mode inside {vmalu_pkg::MODE_REG_REG, vmalu_pkg::MODE_CMP_MEM_REG,
                                      vmalu_pkg::MODE_CMP_IMM_REG};
    end else begin
      bad_mode = 1'b1;
    end
    opnd_a   = first_mem ? req_q.dest_value : rf_a;
    opnd_b   = second_reg ? rf_b : req_q.src_value;
    div_zero = (req_q.operation == vmalu_pkg::OP_DIV) && (opnd_b == '0);
    if (bad_mode) begin
      status_d = vmalu_pkg::ST_BAD_MODE;
    end else if (div_zero) begin
      status_d = vmalu_pkg::ST_DIV_ZERO;
    end else begin
      status_d = vmalu_pkg::ST_OK;
    end
  end

  assign unit_start       = (state_q == S_READ) && (status_d == vmalu_pkg::ST_OK);
  assign unit_cmd.op      = vmalu_pkg::op_e'(req_q.operation);
  assign unit_cmd.dec_sat = !first_mem;

  vmalu_iter_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (unit_start),
    .cmd_i    (unit_cmd),
    .a_i      (opnd_a),
    .b_i      (opnd_b),
    .result_o (unit_res),
    .flags_o  (unit_flags)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_READ;
      S_READ: state_d = unit_start ? S_EXEC : S_DONE;
      S_EXEC: if (unit_flags.done) state_d = S_DONE;
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Flags change only on a successful compare.
  assign new_zf = (load_out && ok && is_cmp_q) ? unit_flags.zero : zf_q;
  assign new_cf = (load_out && ok && is_cmp_q) ? unit_flags.carry : cf_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      zf_q        <= 1'b0;
      cf_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      zf_q    <= new_zf;
      cf_q    <= new_cf;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, decode and output payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (state_q == S_READ) begin
      status_q <= status_d;
      to_mem_q <= first_mem && (req_q.operation != vmalu_pkg::OP_CMP);
      is_cmp_q <= req_q.operation == vmalu_pkg::OP_CMP;
    end
    if (load_out) begin
      out_q.result_value <= (ok && !is_cmp_q) ? unit_res : '0;
      out_q.memory_write <= ok && to_mem_q;
      out_q.zero_flag    <= new_zf;
      out_q.carry_flag   <= new_cf;
      out_q.status       <= status_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // An accepted request is decoded in the very next cycle.
  a_accept_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_READ))
    else $error("accepted request not followed by decode");

  // The register file is written only as an OK result is handed out.
  a_rf_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (load_out && ok))
    else $error("register write outside a successful completion");

  // Flags hold unless a successful compare completes.
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load_out && ok && is_cmp_q) |=> ($stable(zf_q) && $stable(cf_q)))
    else $error("flags changed without a compare");

  // The shared unit reports completion only while the sequencer waits for it.
  a_done_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_flags.done |-> (state_q == S_EXEC))
    else $error("unit completion outside execute state");

endmodule

@@ rtl/vmalu_ram.sv @@
module vmalu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                       rdata_a_o,
  output logic [WIDTH-1:0]                       rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/vmalu_regfile.sv @@
module vmalu_regfile (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [vmalu_pkg::REG_IDX_W-1:0]  rd_idx_a_i,
  input  logic [vmalu_pkg::REG_IDX_W-1:0]  rd_idx_b_i,
  output logic [vmalu_pkg::DATA_W-1:0]     rd_data_a_o,
  output logic [vmalu_pkg::DATA_W-1:0]     rd_data_b_o,
  input  logic                             we_i,
  input  logic [vmalu_pkg::REG_IDX_W-1:0]  wr_idx_i,
  input  logic [vmalu_pkg::DATA_W-1:0]     wr_data_i
);

  logic [vmalu_pkg::REG_COUNT-1:0]  valid_q;
  logic [vmalu_pkg::REG_AW-1:0]     addr_a;
  logic [vmalu_pkg::REG_AW-1:0]     addr_b;
  logic [vmalu_pkg::REG_AW-1:0]     waddr;
  logic                             in_range_a;
  logic                             in_range_b;
  logic                             wr_ok;
  logic                             use_a_q;
  logic                             use_b_q;
  logic [vmalu_pkg::DATA_W-1:0]     ram_a;
  logic [vmalu_pkg::DATA_W-1:0]     ram_b;

  // Index decode; indexes beyond the file read as zero and drop writes.
  assign addr_a     = vmalu_pkg::REG_AW'(rd_idx_a_i);
  assign addr_b     = vmalu_pkg::REG_AW'(rd_idx_b_i);
  assign waddr      = vmalu_pkg::REG_AW'(wr_idx_i);
  assign in_range_a = int'(rd_idx_a_i) < vmalu_pkg::REG_COUNT;
  assign in_range_b = int'(rd_idx_b_i) < vmalu_pkg::REG_COUNT;
  assign wr_ok      = we_i && (int'(wr_idx_i) < vmalu_pkg::REG_COUNT);

  vmalu_ram #(
    .WIDTH (vmalu_pkg::DATA_W),
    .DEPTH (vmalu_pkg::REG_COUNT)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (wr_ok),
    .waddr_i   (waddr),
    .wdata_i   (wr_data_i),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // Valid bits stand in for the reset value of every register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      use_a_q <= 1'b0;
      use_b_q <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid_q[waddr] <= 1'b1;
      end
      use_a_q <= in_range_a && valid_q[addr_a];
      use_b_q <= in_range_b && valid_q[addr_b];
    end
  end

  assign rd_data_a_o = use_a_q ? ram_a : '0;
  assign rd_data_b_o = use_b_q ? ram_b : '0;

endmodule

@@ rtl/vmalu_iter_unit.sv @@
module vmalu_iter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  vmalu_pkg::alu_cmd_t           cmd_i,
  input  logic [vmalu_pkg::DATA_W-1:0]  a_i,
  input  logic [vmalu_pkg::DATA_W-1:0]  b_i,
  output logic [vmalu_pkg::DATA_W-1:0]  result_o,
  output vmalu_pkg::alu_flags_t         flags_o
);

  localparam int W = vmalu_pkg::DATA_W;

  logic                              busy_q;
  logic                              done_q;
  logic [vmalu_pkg::STEP_W-1:0]      cnt_q;
  vmalu_pkg::op_e                    op_q;
  logic                              dec_sat_q;
  logic [W-1:0]                      x_q;
  logic [W-1:0]                      y_q;
  logic [W-1:0]                      acc_q;
  logic [W-1:0]                      res_q;
  logic                              zero_q;
  logic                              carry_q;
  logic [W:0]                        add_x;
  logic [W:0]                        add_y;
  logic                              add_sub;
  logic [W+1:0]                      sum;
  logic                              no_borrow;
  logic [W-1:0]                      rem_next;
  logic [W-1:0]                      quo_next;
  logic [W-1:0]                      simple_res;
  logic                              shift_big;
  logic                              iterative;
  logic                              last_step;

  // Operand selection for the one shared adder.
  always_comb begin
    add_x   = {1'b0, x_q};
    add_y   = {1'b0, y_q};
    add_sub = 1'b0;
    case (op_q)
      vmalu_pkg::OP_MUL: begin
        add_x = {1'b0, acc_q};
        add_y = y_q[0] ? {1'b0, x_q} : '0;
      end
      vmalu_pkg::OP_DIV: begin
        add_x   = {acc_q, x_q[W-1]};
        add_sub = 1'b1;
      end
      vmalu_pkg::OP_SUB, vmalu_pkg::OP_CMP: begin
        add_sub = 1'b1;
      end
      vmalu_pkg::OP_INC: begin
        add_y = (W+1)'(1);
      end
      vmalu_pkg::OP_DEC: begin
        add_y   = (W+1)'(1);
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign sum       = {1'b0, add_x} + {1'b0, add_y ^ {(W+1){add_sub}}} + (W+2)'(add_sub);
  assign no_borrow = sum[W+1];

  // Restoring division step.
  assign rem_next = no_borrow ? sum[W-1:0] : add_x[W-1:0];
  assign quo_next = {x_q[W-2:0], no_borrow};

  // Results of the single-step operations.
  assign shift_big = |y_q[W-1:vmalu_pkg::SHAMT_W];
  always_comb begin
    case (op_q)
      vmalu_pkg::OP_ADD, vmalu_pkg::OP_SUB, vmalu_pkg::OP_INC: simple_res = sum[W-1:0];
      vmalu_pkg::OP_DEC: simple_res = (dec_sat_q && (x_q == '0)) ? '0 : sum[W-1:0];
      vmalu_pkg::OP_AND: simple_res = x_q & y_q;
      vmalu_pkg::OP_OR:  simple_res = x_q | y_q;
      vmalu_pkg::OP_XOR: simple_res = x_q ^ y_q;
      vmalu_pkg::OP_NOT: simple_res = ~x_q;
      vmalu_pkg::OP_SHL: simple_res = shift_big ? '0 : (x_q << y_q[vmalu_pkg::SHAMT_W-1:0]);
      vmalu_pkg::OP_SHR: simple_res = shift_big ? '0 : (x_q >> y_q[vmalu_pkg::SHAMT_W-1:0]);
      default:           simple_res = '0;
    endcase
  end

  assign iterative = (cmd_i.op == vmalu_pkg::OP_MUL) || (cmd_i.op == vmalu_pkg::OP_DIV);
  assign last_step = busy_q && (cnt_q == '0);

  // Sequencer: one step per cycle, 32 steps for multiply and divide.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iterative ? vmalu_pkg::STEP_W'(W - 1) : '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand, partial result and final result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q      <= cmd_i.op;
      dec_sat_q <= cmd_i.dec_sat;
      x_q       <= a_i;
      y_q       <= b_i;
      acc_q     <= '0;
    end else if (busy_q) begin
      case (op_q)
        vmalu_pkg::OP_MUL: begin
          acc_q <= sum[W-1:0];
          x_q   <= x_q << 1;
          y_q   <= y_q >> 1;
        end
        vmalu_pkg::OP_DIV: begin
          acc_q <= rem_next;
          x_q   <= quo_next;
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
      if (last_step) begin
        case (op_q)
          vmalu_pkg::OP_MUL: res_q <= sum[W-1:0];
          vmalu_pkg::OP_DIV: res_q <= quo_next;
          default:           res_q <= simple_res;
        endcase
        zero_q  <= (sum[W-1:0] == '0);
        carry_q <= !no_borrow;
      end
    end
  end

  assign result_o      = res_q;
  assign flags_o.done  = done_q;
  assign flags_o.zero  = zero_q;
  assign flags_o.carry = carry_q;

endmodule
